/* rtl/mzts_pkg.sv */
// ----------------------------------------------------------------------------
// mzts_pkg
// Shared types and constants for the masked zncc template search block.
// ----------------------------------------------------------------------------
package mzts_pkg;

  localparam logic [1:0] ACT_LOAD_SEARCH   = 2'd0;
  localparam logic [1:0] ACT_LOAD_TEMPLATE = 2'd1;
  localparam logic [1:0] ACT_START         = 2'd2;

  localparam logic [2:0] REG_SEARCH_WIDTH    = 3'd0;
  localparam logic [2:0] REG_SEARCH_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_TEMPLATE_WIDTH  = 3'd2;
  localparam logic [2:0] REG_TEMPLATE_HEIGHT = 3'd3;
  localparam logic [2:0] REG_MIN_RATIO       = 3'd4;

  localparam logic signed [17:0] NOT_FOUND_SCORE = -18'sd3277;
  localparam logic [17:0] Q16_ONE = 18'd65536;

  typedef struct packed {
    logic [1:0] action;
    logic [5:0] row;
    logic [5:0] col;
    logic [7:0] pixel;
    logic       valid_req;
  } in_item_t;

  typedef struct packed {
    logic signed [17:0] score_q16;
    logic [5:0]         best_x;
    logic [5:0]         best_y;
    logic               found;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic clr_acc;   // clear the moment sums for a new placement
    logic acc_en;    // accumulate the pixel pair read last cycle
    logic eval_go;   // start scoring the finished placement
    logic best_clr;  // restart the best tracker
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic eval_busy;
  } dp_sts_t;

endpackage

/* rtl/mzts_ram.sv */
// ----------------------------------------------------------------------------
// mzts_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module mzts_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/mzts_score.sv */
// ----------------------------------------------------------------------------
// mzts_score
// Scores one placement: checks and variances, then, if the checks pass, isqrt,
// a restoring divide and an update of the best placement, all sequential.
// ----------------------------------------------------------------------------
module mzts_score (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic        best_clr,
  input  logic [10:0] n,
  input  logic [18:0] ss,
  input  logic [18:0] st,
  input  logic [26:0] sss,
  input  logic [26:0] stt,
  input  logic [26:0] sst,
  input  logic [8:0]  ratio,
  input  logic [10:0] area,
  input  logic [5:0]  pos_x,
  input  logic [5:0]  pos_y,
  output logic        busy,
  output logic        best_found,
  output logic signed [17:0] best_score,
  output logic [5:0]  best_x,
  output logic [5:0]  best_y
);

  import mzts_pkg::*;

  localparam logic [3:0] SC_IDLE = 4'd0;
  localparam logic [3:0] SC_M1   = 4'd1;
  localparam logic [3:0] SC_M2   = 4'd2;
  localparam logic [3:0] SC_VAR  = 4'd3;
  localparam logic [3:0] SC_PM   = 4'd4;
  localparam logic [3:0] SC_SQRT = 4'd5;
  localparam logic [3:0] SC_DIV  = 4'd6;
  localparam logic [3:0] SC_UPD  = 4'd7;

  logic [3:0]  st_r, st_nxt;
  logic [37:0] p_sss_r, p_stt_r, p_sst_r;
  logic [37:0] q_ss_r, q_tt_r, q_st_r;
  logic [37:0] vs_r, vt_r;
  logic signed [38:0] num_r;
  logic        qual_r;
  logic [75:0] prod_r;
  logic        pm_ph_r;
  logic [37:0] root_r;
  logic [77:0] rem_r;
  logic [5:0]  bit_r;
  logic [38:0] dq_r;     // divide quotient
  logic [39:0] drem_r;
  logic [56:0] dnum_r;
  logic [6:0]  dcnt_r;
  logic [5:0]  px_r, py_r;
  logic        best_found_r;
  logic signed [17:0] best_score_r;
  logic [5:0]  best_x_r, best_y_r;

  logic [19:0] ratio_area;
  logic [20:0] n_256;
  logic [77:0] trial;
  logic [39:0] dsh;
  logic [17:0] qmag;
  logic signed [17:0] sc;

  assign ratio_area = ratio * area;
  assign n_256 = {2'b0, n, 8'b0};
  assign busy = (st_r != SC_IDLE);

  // sqrt trial subtraction (restoring, one result bit per cycle)
  assign trial = {rem_r[75:0], prod_r[75:74]};
  // divide trial
  assign dsh = {drem_r[38:0], dnum_r[56]};
  assign qmag = (dq_r > {21'd0, Q16_ONE}) ? Q16_ONE : dq_r[17:0];
  assign sc = num_r[38] ? -$signed(qmag) : $signed(qmag);

  // scoring sequencer
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      SC_IDLE: if (go) st_nxt = SC_M1;
      SC_M1:   st_nxt = SC_M2;
      SC_M2:   st_nxt = SC_VAR;
      SC_VAR:  st_nxt = SC_PM;
      SC_PM:   if (!qual_r) st_nxt = SC_IDLE;
               else if (pm_ph_r) st_nxt = SC_SQRT;
      SC_SQRT: if (bit_r == 6'd0) st_nxt = SC_DIV;
      SC_DIV:  if (dcnt_r == 7'd0) st_nxt = SC_UPD;
      SC_UPD:  st_nxt = SC_IDLE;
      default: st_nxt = SC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= SC_IDLE;
      best_found_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (best_clr) best_found_r <= 1'b0;
      else if (st_r == SC_UPD && (!best_found_r || sc > best_score_r))
        best_found_r <= 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (best_clr) begin
      best_score_r <= NOT_FOUND_SCORE;
      best_x_r <= '0;
      best_y_r <= '0;
    end
    unique case (st_r)
      SC_IDLE: begin
        px_r <= pos_x;
        py_r <= pos_y;
        qual_r <= (n != 11'd0) && (n_256 >= {1'b0, ratio_area});
      end
      SC_M1: begin
        // sums are cleared for the next placement after this cycle
        p_sss_r <= 38'(n * sss);
        p_stt_r <= 38'(n * stt);
        p_sst_r <= 38'(n * sst);
        q_ss_r <= 38'(ss * ss);
        q_tt_r <= 38'(st * st);
        q_st_r <= 38'(ss * st);
      end
      SC_M2: ;
      SC_VAR: begin
        vs_r <= p_sss_r - q_ss_r;
        vt_r <= p_stt_r - q_tt_r;
        num_r <= $signed({1'b0, p_sst_r}) - $signed({1'b0, q_st_r});
        pm_ph_r <= 1'b0;
        prod_r <= '0;
        if (p_sss_r == q_ss_r || p_stt_r == q_tt_r) qual_r <= 1'b0;
      end
      SC_PM: begin
        // vs * vt as two 38x19 partial products
        pm_ph_r <= 1'b1;
        if (!pm_ph_r) prod_r <= 76'(vs_r * vt_r[18:0]);
        else prod_r <= prod_r + (76'(vs_r * vt_r[37:19]) << 19);
        root_r <= '0;
        rem_r <= '0;
        bit_r <= 6'd37;
      end
      SC_SQRT: begin
        if (trial >= {root_r, 2'b01}) begin
          rem_r <= trial - {root_r, 2'b01};
          root_r <= {root_r[36:0], 1'b1};
        end else begin
          rem_r <= trial;
          root_r <= {root_r[36:0], 1'b0};
        end
        prod_r <= {prod_r[73:0], 2'b00};
        bit_r <= bit_r - 6'd1;
        dnum_r <= {2'b0, (num_r[38] ? 39'(-num_r) : 39'(num_r)), 16'd0};
        drem_r <= '0;
        dq_r <= '0;
        dcnt_r <= 7'd56;
      end
      SC_DIV: begin
        // |num| * 65536 / root, truncated
        if (dsh >= {2'b0, root_r}) begin
          drem_r <= dsh - {2'b0, root_r};
          dq_r <= {dq_r[37:0], 1'b1};
        end else begin
          drem_r <= dsh;
          dq_r <= {dq_r[37:0], 1'b0};
        end
        dnum_r <= {dnum_r[55:0], 1'b0};
        dcnt_r <= dcnt_r - 7'd1;
      end
      SC_UPD: begin
        if (!best_found_r || sc > best_score_r) begin
          best_score_r <= sc;
          best_x_r <= px_r;
          best_y_r <= py_r;
        end
      end
      default: ;
    endcase
  end

  assign best_found = best_found_r;
  assign best_score = best_score_r;
  assign best_x = best_x_r;
  assign best_y = best_y_r;

endmodule

/* rtl/mzts_datapath.sv */
// ----------------------------------------------------------------------------
// mzts_datapath
// Pixel stores, moment accumulators and the scoring unit.
// ----------------------------------------------------------------------------
module mzts_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  mzts_pkg::dp_cmd_t   cmd,
  output mzts_pkg::dp_sts_t   sts,
  input  logic                s_we,
  input  logic [11:0]         s_waddr,
  input  logic                t_we,
  input  logic [9:0]          t_waddr,
  input  logic [8:0]          wdata,
  input  logic [11:0]         s_raddr,
  input  logic [9:0]          t_raddr,
  input  logic [8:0]          ratio,
  input  logic [10:0]         area,
  input  logic [5:0]          pos_x,
  input  logic [5:0]          pos_y,
  output logic                best_found,
  output logic signed [17:0]  best_score,
  output logic [5:0]          best_x,
  output logic [5:0]          best_y
);

  import mzts_pkg::*;

  logic [8:0]  s_rd, t_rd;
  logic [10:0] n_r;
  logic [18:0] ss_r, st_r;
  logic [26:0] sss_r, stt_r, sst_r;
  logic        both;

  mzts_ram #(.WIDTH(9), .DEPTH(4096)) u_sram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(wdata),
    .raddr(s_raddr), .rdata(s_rd));

  mzts_ram #(.WIDTH(9), .DEPTH(1024)) u_tram (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(wdata),
    .raddr(t_raddr), .rdata(t_rd));

  assign both = s_rd[0] & t_rd[0];

  // moment accumulators
  always_ff @(posedge clk) begin
    if (cmd.clr_acc) begin
      n_r <= '0; ss_r <= '0; st_r <= '0;
      sss_r <= '0; stt_r <= '0; sst_r <= '0;
    end else if (cmd.acc_en && both) begin
      n_r   <= n_r + 11'd1;
      ss_r  <= ss_r + 19'(s_rd[8:1]);
      st_r  <= st_r + 19'(t_rd[8:1]);
      sss_r <= sss_r + 27'(s_rd[8:1] * s_rd[8:1]);
      stt_r <= stt_r + 27'(t_rd[8:1] * t_rd[8:1]);
      sst_r <= sst_r + 27'(s_rd[8:1] * t_rd[8:1]);
    end
  end

  mzts_score u_score (
    .clk(clk), .rst_n(rst_n), .go(cmd.eval_go), .best_clr(cmd.best_clr),
    .n(n_r), .ss(ss_r), .st(st_r), .sss(sss_r), .stt(stt_r), .sst(sst_r),
    .ratio(ratio), .area(area), .pos_x(pos_x), .pos_y(pos_y),
    .busy(sts.eval_busy), .best_found(best_found), .best_score(best_score),
    .best_x(best_x), .best_y(best_y));

endmodule

/* rtl/mzts_ctrl.sv */
// ----------------------------------------------------------------------------
// mzts_ctrl
// Search sequencer: walks placements and template pixels in raster order.
// ----------------------------------------------------------------------------
module mzts_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [6:0]        sw,
  input  logic [6:0]        sh,
  input  logic [5:0]        tw,
  input  logic [5:0]        th,
  input  mzts_pkg::dp_sts_t sts,
  output mzts_pkg::dp_cmd_t cmd,
  output logic [11:0]       s_raddr,
  output logic [9:0]        t_raddr,
  output logic [5:0]        pos_x,
  output logic [5:0]        pos_y,
  output logic              busy,
  output logic              done
);

  import mzts_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PIX  = 3'd1;
  localparam logic [2:0] ST_LAST = 3'd2;
  localparam logic [2:0] ST_WAIT = 3'd3;
  localparam logic [2:0] ST_NEXT = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [5:0] x_r, y_r, i_r, j_r;
  logic [6:0] xmax, ymax;
  logic       last_pix, last_pos, fits;

  assign xmax = sw - 7'(tw);
  assign ymax = sh - 7'(th);
  assign fits = ({1'b0, tw} <= sw) && ({1'b0, th} <= sh);
  assign last_pix = (j_r == tw - 6'd1) && (i_r == th - 6'd1);
  assign last_pos = (7'(x_r) == xmax) && (7'(y_r) == ymax);
  assign s_raddr = {6'(y_r + i_r), 6'(x_r + j_r)};
  assign t_raddr = {i_r[4:0], j_r[4:0]};
  assign pos_x = x_r;
  assign pos_y = y_r;
  assign busy = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    done = 1'b0;
    unique case (state_r)
      ST_IDLE: if (start) begin
        cmd.best_clr = 1'b1;
        cmd.clr_acc = 1'b1;
        state_nxt = fits ? ST_PIX : ST_FIN;
      end
      ST_PIX: begin
        cmd.acc_en = (i_r != 6'd0) || (j_r != 6'd0);
        if (last_pix) state_nxt = ST_LAST;
      end
      ST_LAST: begin
        cmd.acc_en = 1'b1;
        state_nxt = ST_WAIT;
      end
      ST_WAIT: if (!sts.eval_busy) begin
        cmd.eval_go = 1'b1;
        state_nxt = ST_NEXT;
      end
      ST_NEXT: begin
        cmd.clr_acc = 1'b1;
        state_nxt = last_pos ? ST_FIN : ST_PIX;
      end
      ST_FIN: if (!sts.eval_busy) begin
        done = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    if (state_r == ST_IDLE) begin
      x_r <= '0; y_r <= '0; i_r <= '0; j_r <= '0;
    end else if (state_r == ST_PIX && !last_pix) begin
      if (j_r == tw - 6'd1) begin
        j_r <= '0;
        i_r <= i_r + 6'd1;
      end else begin
        j_r <= j_r + 6'd1;
      end
    end else if (state_r == ST_NEXT && !last_pos) begin
      i_r <= '0;
      j_r <= '0;
      if (7'(x_r) == xmax) begin
        x_r <= '0;
        y_r <= y_r + 6'd1;
      end else begin
        x_r <= x_r + 6'd1;
      end
    end
  end

  property p_go_idle;
    @(posedge clk) disable iff (!rst_n) cmd.eval_go |-> !sts.eval_busy;
  endproperty
  assert property (p_go_idle) else $error("score started while busy");

  property p_done_idle;
    @(posedge clk) disable iff (!rst_n) done |-> !sts.eval_busy;
  endproperty
  assert property (p_done_idle) else $error("done before scoring ended");

  property p_go_next;
    @(posedge clk) disable iff (!rst_n) cmd.eval_go |=> state_r == ST_NEXT;
  endproperty
  assert property (p_go_next) else $error("go not followed by next");

endmodule

/* rtl/masked_zncc_template_search_u8.sv */
// ----------------------------------------------------------------------------
// masked_zncc_template_search_u8
// Masked zncc template search over 8-bit images held in on-chip RAM.
// ----------------------------------------------------------------------------
// Loads are accepted back to back, one transaction per cycle, while no search
// is running and no result is waiting. A start walks (sh-th+1)*(sw-tw+1)
// placements: the RAM read port walks the template pixels while the previous
// placement is scored; scoring stops early if a placement fails its checks.
// The result is offered the cycle after the last scoring ends.
// Reset (synchronous, active low) restores control state and config, not RAMs.
module masked_zncc_template_search_u8 (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mzts_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output mzts_pkg::out_item_t   out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [8:0]            cfg_data
);

  import mzts_pkg::*;

  logic [6:0] sw_r, sh_r;
  logic [5:0] tw_r, th_r;
  logic [8:0] ratio_r;
  logic [6:0] sw_c, sh_c;
  logic [5:0] tw_c, th_c;
  logic       acc, start, busy, done;
  logic       out_valid_r;
  out_item_t  out_r;
  dp_cmd_t    cmd;
  dp_sts_t    sts;
  logic [11:0] s_raddr;
  logic [9:0]  t_raddr;
  logic [5:0]  pos_x, pos_y, bx, by;
  logic        bfound;
  logic signed [17:0] bscore;
  logic signed [18:0] mapped;

  // clamp sizes to their valid range
  assign sw_c = (sw_r == 7'd0) ? 7'd1 : (sw_r > 7'd64) ? 7'd64 : sw_r;
  assign sh_c = (sh_r == 7'd0) ? 7'd1 : (sh_r > 7'd64) ? 7'd64 : sh_r;
  assign tw_c = (tw_r == 6'd0) ? 6'd1 : tw_r;
  assign th_c = (th_r == 6'd0) ? 6'd1 : th_r;

  assign in_ready = !busy && !out_valid_r;
  assign acc = in_valid && in_ready;
  assign start = acc && (in_data.action == ACT_START);
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r <= 7'd64; sh_r <= 7'd64; tw_r <= 6'd32; th_r <= 6'd32;
      ratio_r <= 9'd128;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SEARCH_WIDTH:    sw_r <= cfg_data[6:0];
        REG_SEARCH_HEIGHT:   sh_r <= cfg_data[6:0];
        REG_TEMPLATE_WIDTH:  tw_r <= cfg_data[5:0];
        REG_TEMPLATE_HEIGHT: th_r <= cfg_data[5:0];
        REG_MIN_RATIO:       ratio_r <= cfg_data;
        default: ;
      endcase
    end
  end

  mzts_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .sw(sw_c), .sh(sh_c),
    .tw(tw_c > 6'd32 ? 6'd32 : tw_c), .th(th_c > 6'd32 ? 6'd32 : th_c),
    .sts(sts), .cmd(cmd), .s_raddr(s_raddr), .t_raddr(t_raddr),
    .pos_x(pos_x), .pos_y(pos_y), .busy(busy), .done(done));

  mzts_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .s_we(acc && in_data.action == ACT_LOAD_SEARCH),
    .s_waddr({in_data.row, in_data.col}),
    .t_we(acc && in_data.action == ACT_LOAD_TEMPLATE &&
          !in_data.row[5] && !in_data.col[5]),
    .t_waddr({in_data.row[4:0], in_data.col[4:0]}),
    .wdata({in_data.pixel, in_data.valid_req}),
    .s_raddr(s_raddr), .t_raddr(t_raddr), .ratio(ratio_r),
    .area(11'((tw_c > 6'd32 ? 6'd32 : tw_c) * (th_c > 6'd32 ? 6'd32 : th_c))),
    .pos_x(pos_x), .pos_y(pos_y), .best_found(bfound), .best_score(bscore),
    .best_x(bx), .best_y(by));

  assign mapped = (19'(bscore) + 19'sd65536) >>> 1;

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (done) begin
      out_r.found <= bfound;
      out_r.score_q16 <= bfound ? mapped[17:0] : NOT_FOUND_SCORE;
      out_r.best_x <= bfound ? bx : 6'd0;
      out_r.best_y <= bfound ? by : 6'd0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

  property p_no_take_busy;
    @(posedge clk) disable iff (!rst_n) busy |-> !in_ready;
  endproperty
  assert property (p_no_take_busy) else $error("input taken during search");

  property p_done_out;
    @(posedge clk) disable iff (!rst_n) done |=> out_valid;
  endproperty
  assert property (p_done_out) else $error("result lost");

  property p_found_score;
    @(posedge clk) disable iff (!rst_n)
      (out_valid && !out_data.found) |-> out_data.score_q16 == NOT_FOUND_SCORE;
  endproperty
  assert property (p_found_score) else $error("bad not-found score");

endmodule
